// ----- hdl/ncrs_pkg.sv -----
// ----------------------------------------------------------------------------
// ncrs_pkg
// Shared types, register indexes and type-code helpers for the row select.
// ----------------------------------------------------------------------------
package ncrs_pkg;

   localparam int NUM_BRANCHES = 4;
   localparam int VALUE_W      = 64;
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [2:0] {
      REG_MODE         = 3'd0,
      REG_BRANCH_COUNT = 3'd1,
      REG_OUT_TYPE     = 3'd2,
      REG_BRANCH_TYPE0 = 3'd3,
      REG_BRANCH_TYPE1 = 3'd4,
      REG_BRANCH_TYPE2 = 3'd5,
      REG_BRANCH_TYPE3 = 3'd6
   } reg_index_type;

   localparam logic [1:0] MODE_COALESCE  = 2'd0;
   localparam logic [1:0] MODE_IFNOTNULL = 2'd1;
   localparam logic [1:0] MODE_IIF       = 2'd2;

   localparam logic [3:0] TYPE_NULL = 4'd0;
   localparam logic [3:0] TYPE_I64  = 4'd5;
   localparam logic [3:0] TYPE_F32  = 4'd10;
   localparam logic [3:0] TYPE_F64  = 4'd11;

   typedef enum logic [1:0] {
      CONV_PASS  = 2'd0,   // value already final
      CONV_F32   = 2'd1,   // float32 widening
      CONV_SINT  = 2'd2,   // signed integer to float64
      CONV_UINT  = 2'd3    // unsigned integer to float64
   } conv_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [2:0] branch_count;
      logic [3:0] result_code;
      logic [NUM_BRANCHES-1:0][3:0] branch_type;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      conv_type           conv;
      logic               valid;
      logic [1:0]         branch;
      logic               last;
   } item_type;

   function automatic logic [6:0] type_bits(input logic [3:0] t);
      case (t)
         4'd1:                          type_bits = 7'd1;
         4'd2, 4'd6:                    type_bits = 7'd8;
         4'd3, 4'd7:                    type_bits = 7'd16;
         4'd4, 4'd8, 4'd10, 4'd12, 4'd13: type_bits = 7'd32;
         4'd5, 4'd9, 4'd11, 4'd14, 4'd15: type_bits = 7'd64;
         default:                       type_bits = 7'd0;
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] width_mask(input logic [6:0] w);
      if (w >= 7'd64) width_mask = '1;
      else            width_mask = (64'd1 << w[5:0]) - 64'd1;
   endfunction

   function automatic logic is_signed_type(input logic [3:0] t);
      is_signed_type = (t >= 4'd2) && (t <= 4'd5);
   endfunction

   function automatic logic [VALUE_W-1:0] extend_view(input logic [3:0] t,
                                                     input logic [VALUE_W-1:0] v);
      logic [6:0]         w;
      logic [VALUE_W-1:0] m;
      logic [VALUE_W-1:0] x;
      w = type_bits(t);
      m = width_mask(w);
      x = v & m;
      if (is_signed_type(t) && (w < 7'd64) && x[w[5:0] - 6'd1]) x = x | ~m;
      extend_view = x;
   endfunction

endpackage

// ----- hdl/null_conditional_row_select.sv -----
// ----------------------------------------------------------------------------
// null_conditional_row_select
// Coalesce / if-not-null / IIF row select with output type conversion.
// ----------------------------------------------------------------------------
// One row is taken per cycle and a result leaves per cycle when the result
// side keeps up. A row passes in order through the front's selection
// register, which loads on the accepting edge, an entry of the two-entry
// queue, the leading-zero stage and the normalise/round output register of
// the conversion pipeline, which drives rsp_valid. When the result side
// stalls, the input keeps taking rows until the front register and both
// queue entries are full; with rows streaming at full rate that is one
// further row after the stall begins. The user must write the registers
// through csr_we/csr_index/csr_wdata only while the block is idle; the block
// itself does not enforce it. Writes to an index past the list are ignored.
// ----------------------------------------------------------------------------
module null_conditional_row_select import ncrs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [3:0]         csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value_0,
   input  logic [VALUE_W-1:0] req_value_1,
   input  logic [VALUE_W-1:0] req_value_2,
   input  logic [VALUE_W-1:0] req_value_3,
   input  logic [3:0]         req_valid_mask,
   input  logic               req_cond_valid,
   input  logic               req_cond_true,
   input  logic               req_last_row,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_result_value,
   output logic               rsp_result_valid,
   output logic [1:0]         rsp_chosen_branch,
   output logic               rsp_last_row_out
);

   cfg_type  cfg_ff, cfg_in;
   logic     f_valid, f_ready, q_valid, q_ready;
   item_type f_item, q_item;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MODE:         cfg_in.mode           = csr_wdata[1:0];
            REG_BRANCH_COUNT: cfg_in.branch_count   = csr_wdata[2:0];
            REG_OUT_TYPE:     cfg_in.result_code    = csr_wdata;
            REG_BRANCH_TYPE0: cfg_in.branch_type[0] = csr_wdata;
            REG_BRANCH_TYPE1: cfg_in.branch_type[1] = csr_wdata;
            REG_BRANCH_TYPE2: cfg_in.branch_type[2] = csr_wdata;
            REG_BRANCH_TYPE3: cfg_in.branch_type[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_COALESCE;
         cfg_ff.branch_count   <= 3'd2;
         cfg_ff.result_code    <= TYPE_I64;
         cfg_ff.branch_type[0] <= TYPE_I64;
         cfg_ff.branch_type[1] <= TYPE_I64;
         cfg_ff.branch_type[2] <= TYPE_NULL;
         cfg_ff.branch_type[3] <= TYPE_NULL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: choose the branch and prepare the operand
   ncrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .value_0    (req_value_0),
      .value_1    (req_value_1),
      .value_2    (req_value_2),
      .value_3    (req_value_3),
      .valid_mask (req_valid_mask),
      .cond_valid (req_cond_valid),
      .cond_true  (req_cond_true),
      .last_row   (req_last_row),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_item   (f_item)
   );

   ncrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   // back: float64 conversion and result register
   ncrs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_item       (q_item),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .result_value  (rsp_result_value),
      .result_valid  (rsp_result_valid),
      .chosen_branch (rsp_chosen_branch),
      .last_row_out  (rsp_last_row_out)
   );

endmodule

// ----- hdl/ncrs_front.sv -----
// ----------------------------------------------------------------------------
// ncrs_front
// Branch selection and operand preparation, one registered stage.
// ----------------------------------------------------------------------------
module ncrs_front import ncrs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [VALUE_W-1:0] value_0,
   input  logic [VALUE_W-1:0] value_1,
   input  logic [VALUE_W-1:0] value_2,
   input  logic [VALUE_W-1:0] value_3,
   input  logic [3:0]         valid_mask,
   input  logic               cond_valid,
   input  logic               cond_true,
   input  logic               last_row,
   output logic               out_valid,
   input  logic               out_ready,
   output item_type           out_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic [NUM_BRANCHES-1:0] bvalid;
   logic [VALUE_W-1:0]      vals [NUM_BRANCHES];
   logic                    pick_ok;
   logic [1:0]              pick;
   logic [3:0]              bt;
   logic [VALUE_W-1:0]      x;
   logic [VALUE_W-1:0]      v;
   logic                    cond_sel;

   assign vals[0] = value_0;
   assign vals[1] = value_1;
   assign vals[2] = value_2;
   assign vals[3] = value_3;

   always_comb begin
      for (int k = 0; k < NUM_BRANCHES; k++) begin
         bvalid[k] = valid_mask[k] && (cfg.branch_type[k] != TYPE_NULL);
      end
      pick_ok  = 1'b0;
      pick     = 2'd0;
      cond_sel = !(cond_valid && cond_true);
      case (cfg.mode)
         MODE_COALESCE: begin
            for (int k = NUM_BRANCHES - 1; k >= 0; k--) begin
               if (bvalid[k] && (3'(k) < cfg.branch_count)) begin
                  pick_ok = 1'b1;
                  pick    = 2'(k);
               end
            end
         end
         MODE_IFNOTNULL: begin
            pick_ok = bvalid[0] && bvalid[1];
            pick    = 2'd1;
         end
         MODE_IIF: begin
            pick    = {1'b0, cond_sel};
            pick_ok = bvalid[pick];
         end
         default: ;
      endcase
      bt = cfg.branch_type[pick];
      v  = vals[pick];
      x  = extend_view(bt, v);

      item_in.valid  = pick_ok;
      item_in.branch = pick_ok ? pick : 2'd0;
      item_in.last   = last_row;
      item_in.conv   = CONV_PASS;
      item_in.value  = x & width_mask(type_bits(cfg.result_code));
      if (!pick_ok) begin
         item_in.value = '0;
      end else if (cfg.result_code == TYPE_F64) begin
         if (bt == TYPE_F64) begin
            item_in.value = v;
         end else if (bt == TYPE_F32) begin
            item_in.conv  = CONV_F32;
            item_in.value = {32'd0, v[31:0]};
         end else begin
            item_in.conv  = is_signed_type(bt) ? CONV_SINT : CONV_UINT;
            item_in.value = x;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (in_ready && in_valid) item_ff <= item_in;
   end

endmodule

// ----- hdl/ncrs_queue.sv -----
// ----------------------------------------------------------------------------
// ncrs_queue
// Short FIFO between selection and conversion.
// ----------------------------------------------------------------------------
module ncrs_queue import ncrs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in    = push ? ((wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = pop  ? ((rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

endmodule

// ----- hdl/ncrs_back.sv -----
// ----------------------------------------------------------------------------
// ncrs_back
// Float64 conversion (other results pass through): leading-zero stage, then normalise/round and output.
// ----------------------------------------------------------------------------
module ncrs_back import ncrs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  item_type           in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [VALUE_W-1:0] result_value,
   output logic               result_valid,
   output logic [1:0]         chosen_branch,
   output logic               last_row_out
);

   // stage 1
   logic               s1_valid_ff;
   item_type           s1_item_ff;
   logic               s1_sign_ff, s1_sign_in;
   logic [VALUE_W-1:0] s1_mag_ff, s1_mag_in;
   logic [5:0]         s1_lz_ff, s1_lz_in;
   // output
   logic               o_valid_ff;
   logic [VALUE_W-1:0] o_value_ff, o_value_in;
   logic               o_rv_ff;
   logic [1:0]         o_branch_ff;
   logic               o_last_ff;

   logic               adv;
   logic [VALUE_W-1:0] n;
   logic               rnd;
   logic [62:0]        mag_bits;
   logic [10:0]        e64;
   logic [7:0]         e32;
   logic [22:0]        m32;

   assign adv      = !o_valid_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      s1_sign_in = 1'b0;
      if (in_item.conv == CONV_SINT) s1_sign_in = in_item.value[VALUE_W-1];
      s1_mag_in = s1_sign_in ? (~in_item.value + 64'd1) : in_item.value;
      if (in_item.conv == CONV_F32) s1_mag_in = {41'd0, in_item.value[22:0]};
      s1_lz_in = 6'd0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (s1_mag_in[i]) s1_lz_in = 6'(VALUE_W - 1 - i);
      end
   end

   always_comb begin
      n        = s1_mag_ff << s1_lz_ff;
      rnd      = n[10] && (n[11] || (n[9:0] != '0));
      e64      = 11'(11'd1086 - {5'd0, s1_lz_ff});
      mag_bits = {e64, n[62:11]} + 63'(rnd);
      e32      = s1_item_ff.value[30:23];
      m32      = s1_item_ff.value[22:0];
      case (s1_item_ff.conv)
         CONV_F32: begin
            if (e32 == 8'hFF) begin
               o_value_in = {s1_item_ff.value[31], 11'h7FF, m32 != '0, m32[21:0], 29'd0}
                            | {12'd0, m32[22], 51'd0};
            end else if (e32 == 8'd0) begin
               if (m32 == '0) o_value_in = {s1_item_ff.value[31], 63'd0};
               else o_value_in = {s1_item_ff.value[31], 11'(11'd937 - {5'd0, s1_lz_ff}),
                                  n[62:40], 29'd0};
            end else begin
               o_value_in = {s1_item_ff.value[31], 11'({3'd0, e32} + 11'd896), m32, 29'd0};
            end
         end
         CONV_SINT, CONV_UINT: begin
            if (s1_mag_ff == '0) o_value_in = '0;
            else                 o_value_in = {s1_sign_ff, mag_bits};
         end
         default: o_value_in = s1_item_ff.value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         o_valid_ff  <= s1_valid_ff;
      end
      if (adv) begin
         s1_item_ff  <= in_item;
         s1_sign_ff  <= s1_sign_in;
         s1_mag_ff   <= s1_mag_in;
         s1_lz_ff    <= s1_lz_in;
         o_value_ff  <= o_value_in;
         o_rv_ff     <= s1_item_ff.valid;
         o_branch_ff <= s1_item_ff.branch;
         o_last_ff   <= s1_item_ff.last;
      end
   end

   assign out_valid     = o_valid_ff;
   assign result_value  = o_value_ff;
   assign result_valid  = o_rv_ff;
   assign chosen_branch = o_branch_ff;
   assign last_row_out  = o_last_ff;

endmodule

// ----- hdl/ncrs_checker.sv -----
// ----------------------------------------------------------------------------
// ncrs_checker
// Port-level checks on the row select, bound to the top level.
// ----------------------------------------------------------------------------
module ncrs_checker import ncrs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VALUE_W-1:0] rsp_result_value,
   input logic               rsp_result_valid,
   input logic [1:0]         rsp_chosen_branch
);

   // a null row carries zero value and branch
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_valid |-> rsp_result_value == '0 && rsp_chosen_branch == 2'd0)
      else $error("null row with non-zero payload");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

   // a waiting row stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before transfer");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
      else $error("stalled result changed");

endmodule

bind null_conditional_row_select ncrs_checker u_ncrs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_value  (rsp_result_value),
   .rsp_result_valid  (rsp_result_valid),
   .rsp_chosen_branch (rsp_chosen_branch)
);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the null-conditional row select. A predictor works
// out each row's result from the shadowed register settings and a checker
// compares every rsp transfer with the oldest prediction. Both handshake
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import ncrs_pkg::*;

   // type codes not named in the package
   localparam logic [3:0] TYPE_BOOL = 4'd1;
   localparam logic [3:0] TYPE_I8   = 4'd2;
   localparam logic [3:0] TYPE_I16  = 4'd3;
   localparam logic [3:0] TYPE_I32  = 4'd4;
   localparam logic [3:0] TYPE_U8   = 4'd6;
   localparam logic [3:0] TYPE_U16  = 4'd7;
   localparam logic [3:0] TYPE_U32  = 4'd8;
   localparam logic [3:0] TYPE_U64  = 4'd9;
   localparam logic [3:0] TYPE_DATE = 4'd12;
   localparam logic [3:0] TYPE_T32  = 4'd13;
   localparam logic [3:0] TYPE_TS   = 4'd14;
   localparam logic [3:0] TYPE_T64  = 4'd15;
   localparam logic [1:0] MODE_NULL = 2'd3;     // undefined mode, always null
   localparam logic [2:0] REG_NONE  = 3'd7;     // index past the register list
   localparam int         DRAIN_CYCLES = 8;     // margin after the last result
   localparam int         IDLE_LIMIT   = 4000;

   typedef struct {
      logic [VALUE_W-1:0] value [4];
      logic [3:0]         mask;
      logic               cond_valid;
      logic               cond_true;
      logic               last;
   } row_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               valid;
      logic [1:0]         branch;
      logic               last;
   } outcome_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [3:0]         csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic [VALUE_W-1:0] req_value_0, req_value_1, req_value_2, req_value_3;
   logic [3:0]         req_valid_mask;
   logic               req_cond_valid;
   logic               req_cond_true;
   logic               req_last_row;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [VALUE_W-1:0] rsp_result_value;
   logic               rsp_result_valid;
   logic [1:0]         rsp_chosen_branch;
   logic               rsp_last_row_out;

   null_conditional_row_select DUT (.*);

   // shadow of the register file
   logic [1:0] sel_mode;
   logic [2:0] scan_count;
   logic [3:0] result_type;
   logic [3:0] branch_kind [4];

   outcome_type pending_rows [$];
   int         mismatches;
   int         rows_sent;
   int         rows_checked;
   int         null_rows;
   bit         sender_steady;    // no gaps on the req side
   bit         receiver_steady;  // no stalls on the rsp side
   int         hold_request;     // long rsp stall asked for by a test

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic int width_of(logic [3:0] t);
      case (t)
         TYPE_BOOL:                                       return 1;
         TYPE_I8, TYPE_U8:                                return 8;
         TYPE_I16, TYPE_U16:                              return 16;
         TYPE_I32, TYPE_U32, TYPE_F32, TYPE_DATE, TYPE_T32: return 32;
         TYPE_NULL:                                       return 0;
         default:                                         return 64;
      endcase
   endfunction

   function automatic logic [63:0] low_ones(int w);
      return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
   endfunction

   function automatic bit signed_kind(logic [3:0] t);
      return (t >= TYPE_I8) && (t <= TYPE_I64);
   endfunction

   // raw bits seen at the branch width, sign- or zero-extended
   function automatic logic [63:0] widen_raw(logic [3:0] t, logic [63:0] v);
      int          w;
      logic [63:0] x;
      w = width_of(t);
      x = v & low_ones(w);
      if (signed_kind(t) && w < 64 && x[w-1]) x = x | ~low_ones(w);
      return x;
   endfunction

   function automatic logic [63:0] single_to_double(logic [31:0] f);
      logic [63:0] sgn;
      logic [7:0]  ex;
      logic [22:0] man;
      int          sh;
      sgn = {f[31], 63'd0};
      ex  = f[30:23];
      man = f[22:0];
      if (ex == 8'hFF)
         return sgn | (64'd2047 << 52) | ({41'd0, man} << 29) | ((man != 0) ? (64'd1 << 51) : 0);
      if (ex == 8'd0) begin
         if (man == 0) return sgn;
         sh = 0;
         while (!man[22 - sh]) sh++;
         // normalise: the leading one drops out as the hidden bit
         return sgn | (64'(897 - 1 - sh) << 52) | ({41'd0, 23'(man << (sh + 1))} << 29);
      end
      return sgn | (64'(ex + 896) << 52) | ({41'd0, man} << 29);
   endfunction

   // integer to float64, round to nearest even
   function automatic logic [63:0] int_to_double(logic [63:0] x, bit is_signed);
      logic        neg;
      logic [63:0] mag, kept, rest, half;
      int          top, sh;
      logic [10:0] ex;
      neg = is_signed && x[63];
      mag = neg ? (~x + 64'd1) : x;
      if (mag == 0) return 64'd0;
      top = 63;
      while (!mag[top]) top--;
      ex = 11'(1023 + top);
      if (top <= 52) begin
         kept = mag << (52 - top);
      end else begin
         sh   = top - 52;
         kept = mag >> sh;
         rest = mag & low_ones(sh);
         half = 64'd1 << (sh - 1);
         if (rest > half || (rest == half && kept[0])) kept = kept + 64'd1;
         if (kept[53]) begin
            kept = kept >> 1;
            ex   = ex + 11'd1;
         end
      end
      return {neg, ex, kept[51:0]};
   endfunction

   function automatic logic [63:0] to_result_type(logic [3:0] bt, logic [63:0] v);
      logic [63:0] x;
      x = widen_raw(bt, v);
      if (result_type == TYPE_F64) begin
         if (bt == TYPE_F64) return v;
         if (bt == TYPE_F32) return single_to_double(v[31:0]);
         return int_to_double(x, signed_kind(bt));
      end
      return x & low_ones(width_of(result_type));
   endfunction

   function automatic bit usable(int k, logic [3:0] mask);
      return (branch_kind[k] != TYPE_NULL) && mask[k];
   endfunction

   function automatic outcome_type select_row(row_type r);
      outcome_type o;
      int       pick, c;
      pick = -1;
      case (sel_mode)
         MODE_COALESCE:
            for (int k = 0; k < scan_count && k < NUM_BRANCHES; k++)
               if (pick < 0 && usable(k, r.mask)) pick = k;
         MODE_IFNOTNULL:
            if (usable(0, r.mask) && usable(1, r.mask)) pick = 1;
         MODE_IIF: begin
            c = (r.cond_valid && r.cond_true) ? 0 : 1;
            if (usable(c, r.mask)) pick = c;
         end
         default: pick = -1;
      endcase
      o.last = r.last;
      if (pick < 0) begin
         o.value  = '0;
         o.valid  = 1'b0;
         o.branch = 2'd0;
      end else begin
         o.value  = to_result_type(branch_kind[pick], r.value[pick]);
         o.valid  = 1'b1;
         o.branch = 2'(pick);
      end
      return o;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("ERROR row %0d %s: got %h, want %h", rows_checked, what, got, want);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rows.size() == 0) begin
            report("unexpected result", rsp_result_value, 64'd0);
         end else begin
            want = pending_rows.pop_front();
            if (rsp_result_value !== want.value)
               report("result_value", rsp_result_value, want.value);
            if (rsp_result_valid !== want.valid)
               report("result_valid", 64'(rsp_result_valid), 64'(want.valid));
            if (rsp_chosen_branch !== want.branch)
               report("chosen_branch", 64'(rsp_chosen_branch), 64'(want.branch));
            if (rsp_last_row_out !== want.last)
               report("last_row_out", 64'(rsp_last_row_out), 64'(want.last));
            if (!want.valid) null_rows++;
         end
         rows_checked++;
      end
   end

   // result side: random stalls, and long holds on request
   always @(posedge clock) begin
      int hold;
      int roll;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold = 0;
      end else begin
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
         end
         roll = $urandom_range(99);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (receiver_steady || roll < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            if (roll >= 97) hold = $urandom_range(30, 5);
         end
      end
   end

   // watchdog: no transfer on either side for too long
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic send_row(row_type r);
      int gap;
      int roll;
      roll = $urandom_range(99);
      gap  = sender_steady ? 0 : (roll < 60) ? 0 : (roll < 90) ?
             $urandom_range(3, 1) : $urandom_range(30, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_value_0    <= r.value[0];
      req_value_1    <= r.value[1];
      req_value_2    <= r.value[2];
      req_value_3    <= r.value[3];
      req_valid_mask <= r.mask;
      req_cond_valid <= r.cond_valid;
      req_cond_true  <= r.cond_true;
      req_last_row   <= r.last;
      do @(posedge clock); while (!req_ready);
      pending_rows.push_back(select_row(r));
      rows_sent++;
   endtask

   // wait for every result, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [3:0] data);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_MODE:         sel_mode    = data[1:0];
         REG_BRANCH_COUNT: scan_count  = data[2:0];
         REG_OUT_TYPE:     result_type = data;
         REG_BRANCH_TYPE0: branch_kind[0] = data;
         REG_BRANCH_TYPE1: branch_kind[1] = data;
         REG_BRANCH_TYPE2: branch_kind[2] = data;
         REG_BRANCH_TYPE3: branch_kind[3] = data;
         default: ;
      endcase
   endtask

   task automatic set_types(logic [3:0] t0, logic [3:0] t1, logic [3:0] t2,
                            logic [3:0] t3, logic [3:0] out);
      write_reg(REG_BRANCH_TYPE0, t0);
      write_reg(REG_BRANCH_TYPE1, t1);
      write_reg(REG_BRANCH_TYPE2, t2);
      write_reg(REG_BRANCH_TYPE3, t3);
      write_reg(REG_OUT_TYPE, out);
   endtask

   // values biased towards edges and float specials
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(11))
         0: v = '0;
         1: v = '1;
         2: v = 64'd1 << $urandom_range(63);
         3: v = {32'd0, v[31], 8'hFF, v[22:0]};           // f32 inf / NaN
         4: v = {32'd0, v[31], 8'h00, v[22:0] >> $urandom_range(22)}; // subnormal
         5: v = {1'b1, 63'd0};
         6: v = v >> $urandom_range(63);
         7: v = {v[63:32], 1'b1, v[30:0]};
         default: ;
      endcase
      return v;
   endfunction

   function automatic row_type random_row();
      row_type r;
      foreach (r.value[k]) r.value[k] = pick_value();
      r.mask       = 4'($urandom);
      r.cond_valid = 1'($urandom);
      r.cond_true  = 1'($urandom);
      r.last       = ($urandom_range(7) == 0);
      return r;
   endfunction

   function automatic row_type make_row(logic [63:0] v0, logic [63:0] v1, logic [3:0] mask,
                                        bit cv = 1'b0, bit ct = 1'b0);
      row_type r;
      r = random_row();
      r.value[0]   = v0;
      r.value[1]   = v1;
      r.mask       = mask;
      r.cond_valid = cv;
      r.cond_true  = ct;
      return r;
   endfunction

   // ---------------------------------------------------------------- tests
   // reset settings: coalesce over two int64 branches into int64
   task automatic test_reset_settings();
      send_row(make_row(64'h8000_0000_0000_0000, 64'd5, 4'b0001));
      send_row(make_row(64'd7, '1, 4'b0010));
      send_row(make_row(64'd7, 64'd9, 4'b1100));
   endtask

   task automatic test_coalesce();
      set_types(TYPE_I8, TYPE_U16, TYPE_I32, TYPE_U64, TYPE_I64);
      write_reg(REG_BRANCH_COUNT, 4'd4);
      send_row(make_row(64'hFF, 64'hFFFF, 4'b0001));
      send_row(make_row(64'hFF, 64'hFFFF, 4'b0010));
      send_row(make_row(64'd0, 64'd0, 4'b0100));
      send_row(make_row(64'd0, 64'd0, 4'b1000));
      // typed null branch skipped even with its mask bit set
      write_reg(REG_BRANCH_TYPE0, TYPE_NULL);
      send_row(make_row(64'd3, 64'd4, 4'b0011));
      // count out of range, then zero
      write_reg(REG_BRANCH_COUNT, 4'd7);
      send_row(make_row(64'd3, 64'd4, 4'b1000));
      write_reg(REG_BRANCH_COUNT, 4'd0);
      send_row(make_row(64'd3, 64'd4, 4'b1111));
   endtask

   task automatic test_ifnotnull_iif();
      set_types(TYPE_I16, TYPE_I16, TYPE_I16, TYPE_I16, TYPE_I32);
      write_reg(REG_MODE, {2'b00, MODE_IFNOTNULL});
      send_row(make_row(64'h8001, 64'h7FFF, 4'b0011));
      send_row(make_row(64'h8001, 64'h7FFF, 4'b0010));
      write_reg(REG_MODE, {2'b00, MODE_IIF});
      send_row(make_row(64'h1, 64'h2, 4'b0011, 1'b1, 1'b1));
      send_row(make_row(64'h1, 64'h2, 4'b0011, 1'b1, 1'b0));
      send_row(make_row(64'h1, 64'h2, 4'b0001, 1'b0, 1'b1));
      write_reg(REG_MODE, {2'b00, MODE_NULL});
      send_row(make_row(64'h1, 64'h2, 4'b1111, 1'b1, 1'b1));
      write_reg(REG_NONE, 4'hF);   // ignored
      send_row(make_row(64'h1, 64'h2, 4'b1111));
   endtask

   task automatic test_conversions();
      write_reg(REG_MODE, {2'b00, MODE_IIF});
      set_types(TYPE_F32, TYPE_I64, TYPE_NULL, TYPE_NULL, TYPE_F64);
      send_row(make_row(64'h0000_0001, 64'd0, 4'b0001, 1'b1, 1'b1)); // f32 subnormal
      send_row(make_row(64'h7FA0_0001, 64'd0, 4'b0001, 1'b1, 1'b1)); // signalling NaN
      send_row(make_row(64'hFF80_0000, 64'd0, 4'b0001, 1'b1, 1'b1)); // -inf
      send_row(make_row(64'd0, 64'h8000_0000_0000_0000, 4'b0010));   // int64 min
      send_row(make_row(64'd0, 64'h0020_0000_0000_0001, 4'b0010));   // tie, rounds down
      send_row(make_row(64'd0, 64'h0020_0000_0000_0003, 4'b0010));   // tie, rounds up
      set_types(TYPE_U64, TYPE_F64, TYPE_NULL, TYPE_NULL, TYPE_F32);
      send_row(make_row('1, 64'h4009_21FB_5444_2D18, 4'b0010));    // f64 into f32
      write_reg(REG_OUT_TYPE, TYPE_NULL);
      send_row(make_row('1, '1, 4'b0011, 1'b1, 1'b1));
      write_reg(REG_OUT_TYPE, TYPE_BOOL);
      send_row(make_row('1, '1, 4'b0011, 1'b1, 1'b1));
   endtask

   // receiver holds off while rows keep coming, so the input stalls
   task automatic test_backpressure();
      drain();
      sender_steady = 1'b1;
      hold_request  = 60;
      repeat (20) send_row(random_row());
      sender_steady = 1'b0;
      drain();   // sender waits for every outstanding result
   endtask

   task automatic test_random();
      logic [3:0] t [4];
      logic [3:0] out;
      for (int phase = 0; phase < 12; phase++) begin
         foreach (t[k]) t[k] = 4'($urandom);
         out = (phase % 3 == 0) ? TYPE_F64 : 4'($urandom_range(15, 1));
         if (phase == 1) begin
            t = '{TYPE_NULL, TYPE_NULL, TYPE_NULL, TYPE_NULL};
            out = TYPE_T64;
         end
         set_types(t[0], t[1], t[2], t[3], out);
         write_reg(REG_MODE, 4'($urandom));
         write_reg(REG_BRANCH_COUNT, (phase == 2) ? 4'd2 : 4'($urandom));
         receiver_steady = (phase == 5);
         sender_steady   = (phase == 5) || (phase == 8);
         repeat (50) send_row(random_row());
      end
      receiver_steady = 1'b0;
      sender_steady   = 1'b0;
   endtask

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= REG_MODE;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_value_0    <= '0;
      req_value_1    <= '0;
      req_value_2    <= '0;
      req_value_3    <= '0;
      req_valid_mask <= '0;
      req_cond_valid <= 1'b0;
      req_cond_true  <= 1'b0;
      req_last_row   <= 1'b0;
      sel_mode       = MODE_COALESCE;
      scan_count     = 3'd2;
      result_type    = TYPE_I64;
      branch_kind    = '{TYPE_I64, TYPE_I64, TYPE_NULL, TYPE_NULL};
      mismatches     = 0;
      rows_sent      = 0;
      rows_checked   = 0;
      null_rows      = 0;
      sender_steady  = 1'b0;
      receiver_steady = 1'b0;
      hold_request   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_coalesce();
      test_ifnotnull_iif();
      test_conversions();
      test_backpressure();
      test_random();
      drain();

      $display("Rows sent %0d, results checked %0d, of them null %0d", rows_sent,
               rows_checked, null_rows);
      $display("Covered: all modes, typed nulls, count extremes, int/float conversions");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/ncrs_pkg.sv
hdl/ncrs_front.sv
hdl/ncrs_queue.sv
hdl/ncrs_back.sv
hdl/null_conditional_row_select.sv
hdl/ncrs_checker.sv
tb/sv/tb_top.sv
